// ===== sv/psma_pkg.sv =====
// Shared types, sizes and codes for the per-sensor moving average alarm.
// Depends on nothing; psma_div, the top level and the testbench import it.
package psma_pkg;

    // Table and window geometry.
    localparam int SENSOR_SLOTS = 16;
    localparam int WINDOW_LEN   = 5;

    // Field widths fixed by the interface.
    localparam int TEMP_W     = 16;
    localparam int IDENT_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_IDX_W  = 2;

    // Derived widths.
    localparam int SLOT_W  = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
    localparam int COUNT_W = $clog2(SENSOR_SLOTS + 1);
    localparam int ELEM_W  = $clog2(WINDOW_LEN);
    localparam int DIV_W   = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W   = TEMP_W + 1 + $clog2(WINDOW_LEN);
    localparam int ROW_W   = WINDOW_LEN * TEMP_W;
    localparam int ENTRY_W = 2 * IDENT_W;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_AVERAGED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REGISTERED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 2'd1;

    // Threshold reset values, Q7.8.
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 16'sd6400;
    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RESET = 16'sd2560;

    // Function codes of an input transaction.
    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_SAMPLE   = 1'b1;

    // One pending result.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SLOT_W-1:0]        slot;
        logic [IDENT_W-1:0]       room;
        logic signed [TEMP_W-1:0] average;
        logic                     too_hot;
        logic                     too_cold;
    } psma_result_t;

endpackage

// ===== sv/psma_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module psma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/psma_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on psma_pkg for the dividend and divisor widths.
module psma_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [psma_pkg::SUM_W-1:0]  dividend,
    input  logic [psma_pkg::DIV_W-1:0]         divisor,
    output logic                               done,
    output logic signed [psma_pkg::SUM_W-1:0]  quotient
);
    import psma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_W:0]    partial;
    logic [DIV_W:0]    trial;

    // Shift-subtract step on the magnitude.
    assign partial = {rem_reg, quo_reg[SUM_W-1]};
    assign trial   = partial - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (run_reg)
        begin
            if (trial[DIV_W] == 1'b0)
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // Apply the sign of the dividend to the magnitude quotient.
    assign done     = done_reg;
    assign quotient = neg_reg ? signed'(~quo_reg + 1'b1) : signed'(quo_reg);

endmodule

// ===== sv/per_sensor_moving_average_alarm.sv =====
// Top level of the per-sensor moving average temperature alarm.
// Depends on psma_pkg, psma_ram (id/room table, sample windows) and psma_div.

// A registration transaction (func 0) appends a sensor to the table, clearing
// its window; a full table gives status 3. A sample transaction (func 1)
// searches the id table one slot per cycle through the table RAM read port,
// reads and rewrites the slot's window row, sums the WINDOW_LEN samples with
// one adder, and then runs the shift-subtract divider: a start, SUM_W (20)
// shift steps and a hand-back of the quotient. A sample's steps run in order:
// search, window read and rewrite, sum, divide and finish. An unknown id gives
// status 1 once every entry has been searched, or without a search when the
// table is empty. The block takes one transaction at a time: in_ready is high
// only while the sequencer is idle, but the next transaction may be accepted
// while the previous result still waits in the output register. Configuration
// writes are taken in any cycle; the thresholds are read when the divide
// finishes, so they are written only while no transaction is in flight, a rule
// on the user that the block itself does not enforce. No clearing pass is
// needed.
module per_sensor_moving_average_alarm (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psma_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psma_pkg::TEMP_W-1:0]           cfg_data,
    // Input channel.
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic [psma_pkg::IDENT_W-1:0]          sensor_ident,
    input  logic [psma_pkg::IDENT_W-1:0]          room_ident,
    input  logic signed [psma_pkg::TEMP_W-1:0]    sample_value,
    // Output channel.
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [psma_pkg::STATUS_W-1:0]         status,
    output logic [psma_pkg::SLOT_OUT_W-1:0]       slot_index,
    output logic [psma_pkg::IDENT_W-1:0]          room_out,
    output logic signed [psma_pkg::TEMP_W-1:0]    running_average,
    output logic                                  too_hot,
    output logic                                  too_cold
);
    import psma_pkg::*;

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_WREAD  = 3'd2;
    localparam logic [2:0] S_WLOAD  = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    localparam logic signed [SUM_W-1:0] AVG_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] AVG_LO = -SUM_W'(32768);

    logic [2:0]                state_reg, state_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [COUNT_W-1:0]        scan_reg, scan_next;
    logic                      look_valid_reg, look_valid_next;
    logic [SLOT_W-1:0]         look_idx_reg, look_idx_next;
    logic [ELEM_W-1:0]         elem_reg, elem_next;
    logic [IDENT_W-1:0]        ident_reg, ident_next;
    logic signed [TEMP_W-1:0]  sample_reg, sample_next;
    logic [ROW_W-1:0]          win_reg, win_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic [DIV_W-1:0]          dsr_reg, dsr_next;
    logic signed [TEMP_W-1:0]  max_temp_reg, max_temp_next;
    logic signed [TEMP_W-1:0]  min_temp_reg, min_temp_next;
    psma_result_t              res_reg, res_next;
    psma_result_t              out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      div_kick_reg;

    // RAM and divider hookup.
    logic                      id_we;
    logic [SLOT_W-1:0]         id_waddr, id_raddr;
    logic [ENTRY_W-1:0]        id_wdata, id_rdata;
    logic                      win_we;
    logic [SLOT_W-1:0]         win_waddr, win_raddr;
    logic [ROW_W-1:0]          win_wdata, win_rdata;
    logic                      div_done;
    logic signed [SUM_W-1:0]   div_quot;
    logic signed [SUM_W-1:0]   avg_sat;
    logic signed [TEMP_W-1:0]  elem;
    logic [ROW_W-1:0]          shifted_row;

    psma_ram #(.WIDTH(ENTRY_W), .DEPTH(SENSOR_SLOTS)) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .raddr (id_raddr),
        .rdata (id_rdata)
    );

    psma_ram #(.WIDTH(ROW_W), .DEPTH(SENSOR_SLOTS)) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // The divider is started from the registered kick, once the sum has settled.
    psma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_kick_reg),
        .dividend (acc_reg),
        .divisor  (dsr_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Oldest sample sits in the low element of a row; a new sample enters at the top.
    assign shifted_row = {sample_reg, win_rdata[ROW_W-1:TEMP_W]};
    assign elem        = signed'(win_reg[TEMP_W-1:0]);

    // Clamp the quotient to the 16-bit range.
    always_comb
    begin
        if (div_quot > AVG_HI)
        begin
            avg_sat = AVG_HI;
        end
        else if (div_quot < AVG_LO)
        begin
            avg_sat = AVG_LO;
        end
        else
        begin
            avg_sat = div_quot;
        end
    end

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        max_temp_next = max_temp_reg;
        min_temp_next = min_temp_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_TEMP: max_temp_next = signed'(cfg_data);
                CFG_MIN_TEMP: min_temp_next = signed'(cfg_data);
                default:      ;
            endcase
        end
    end

    // Main sequencer.
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        look_valid_next = look_valid_reg;
        look_idx_next   = look_idx_reg;
        elem_next       = elem_reg;
        ident_next      = ident_reg;
        sample_next     = sample_reg;
        win_next        = win_reg;
        acc_next        = acc_reg;
        dsr_next        = dsr_reg;
        res_next        = res_reg;
        id_we           = 1'b0;
        id_waddr        = count_reg[SLOT_W-1:0];
        id_wdata        = {sensor_ident, room_ident};
        id_raddr        = scan_reg[SLOT_W-1:0];
        win_we          = 1'b0;
        win_waddr       = count_reg[SLOT_W-1:0];
        win_wdata       = '0;
        win_raddr       = res_reg.slot;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ident_next  = sensor_ident;
                    sample_next = sample_value;
                    res_next    = '0;
                    if (func == FUNC_REGISTER)
                    begin
                        if (count_reg == COUNT_W'(SENSOR_SLOTS))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            // Append the entry and clear its window row.
                            id_we           = 1'b1;
                            win_we          = 1'b1;
                            count_next      = count_reg + 1'b1;
                            res_next.status = ST_REGISTERED;
                            res_next.slot   = count_reg[SLOT_W-1:0];
                            res_next.room   = room_ident;
                        end
                        state_next = S_FIN;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = ST_UNKNOWN;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        scan_next       = '0;
                        look_valid_next = 1'b0;
                        state_next      = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // Reads are issued one slot ahead of the compare.
                if (look_valid_reg && (id_rdata[ENTRY_W-1:IDENT_W] == ident_reg))
                begin
                    res_next.slot = look_idx_reg;
                    res_next.room = id_rdata[IDENT_W-1:0];
                    state_next    = S_WREAD;
                end
                else if (scan_reg < count_reg)
                begin
                    look_valid_next = 1'b1;
                    look_idx_next   = scan_reg[SLOT_W-1:0];
                    scan_next       = scan_reg + 1'b1;
                end
                else
                begin
                    look_valid_next = 1'b0;
                    if (!look_valid_reg)
                    begin
                        res_next        = '0;
                        res_next.status = ST_UNKNOWN;
                        state_next      = S_FIN;
                    end
                end
            end

            S_WREAD:
            begin
                state_next = S_WLOAD;
            end

            S_WLOAD:
            begin
                // Shift in the new sample and write the row back.
                win_we     = 1'b1;
                win_waddr  = res_reg.slot;
                win_wdata  = shifted_row;
                win_next   = shifted_row;
                acc_next   = '0;
                dsr_next   = DIV_W'(1);
                elem_next  = '0;
                state_next = S_SUM;
            end

            S_SUM:
            begin
                // One element per cycle; older nonzero samples add to the divisor.
                acc_next = acc_reg + SUM_W'(elem);
                win_next = win_reg >> TEMP_W;
                if ((elem_reg != ELEM_W'(WINDOW_LEN - 1)) && (elem != '0))
                begin
                    dsr_next = dsr_reg + 1'b1;
                end
                elem_next = elem_reg + 1'b1;
                if (elem_reg == ELEM_W'(WINDOW_LEN - 1))
                begin
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_next.status   = ST_AVERAGED;
                    res_next.average  = avg_sat[TEMP_W-1:0];
                    res_next.too_hot  = (avg_sat > SUM_W'(max_temp_reg));
                    res_next.too_cold = (avg_sat < SUM_W'(min_temp_reg));
                    state_next        = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The divider sees the finished sum in the cycle after the sum loop ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_kick_reg <= 1'b0;
        end
        else
        begin
            div_kick_reg <= (state_reg == S_SUM) && (elem_reg == ELEM_W'(WINDOW_LEN - 1));
        end
    end

    // Output register: loaded from the pending result, held until taken.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_FIN) && (!out_valid_reg || out_ready))
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            look_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_temp_reg   <= MAX_TEMP_RESET;
            min_temp_reg   <= MIN_TEMP_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            look_valid_reg <= look_valid_next;
            out_valid_reg  <= out_valid_next;
            max_temp_reg   <= max_temp_next;
            min_temp_reg   <= min_temp_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        look_idx_reg <= look_idx_next;
        elem_reg     <= elem_next;
        ident_reg    <= ident_next;
        sample_reg   <= sample_next;
        win_reg      <= win_next;
        acc_reg      <= acc_next;
        dsr_reg      <= dsr_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // Port drive.
    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign slot_index      = SLOT_OUT_W'(out_reg.slot);
    assign room_out        = out_reg.room;
    assign running_average = out_reg.average;
    assign too_hot         = out_reg.too_hot;
    assign too_cold        = out_reg.too_cold;

`ifndef ASSERT_OFF
    // The table never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(SENSOR_SLOTS))
        else $error("entry count beyond table size");

    // A divider result only arrives while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // The search never runs past the registered entries.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (scan_reg <= count_reg))
        else $error("search index beyond entry count");

    // A new result is loaded only from the finish state.
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result presented without finishing a transaction");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the per-sensor moving average alarm.
// Depends on psma_pkg and per_sensor_moving_average_alarm; drives directed
// and random transactions and checks every result against a local model.
module testbench;
    import psma_pkg::*;

    // Run geometry.
    localparam int RAND_SEGMENTS = 6;
    localparam int SEG_ITEMS     = 305;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_AT       = 1400;
    localparam int HOLD_LEN      = 400;
    localparam int MAX_REPORTS   = 10;

    // What one entry of the plan asks the driver to do.
    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_CFG,
        ENT_SETTLE
    } plan_kind_e;

    typedef struct packed {
        plan_kind_e               kind;
        logic                     op;
        logic [IDENT_W-1:0]       ident;
        logic [IDENT_W-1:0]       room;
        logic [TEMP_W-1:0]        temp;
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [TEMP_W-1:0]        reg_data;
    } plan_entry_t;

    // Clock, reset and block inputs, all known from time zero.
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [TEMP_W-1:0]          cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       func = 1'b0;
    logic [IDENT_W-1:0]         sensor_ident = '0;
    logic [IDENT_W-1:0]         room_ident = '0;
    logic signed [TEMP_W-1:0]   sample_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic [SLOT_OUT_W-1:0]      slot_index;
    logic [IDENT_W-1:0]         room_out;
    logic signed [TEMP_W-1:0]   running_average;
    logic                       too_hot;
    logic                       too_cold;

    // Plan, expected results and bookkeeping.
    plan_entry_t    item_plan[$];
    psma_result_t   pending_results[$];
    int             items_sent = 0;
    int             total_items = 1;
    int             results_seen = 0;
    int             fail_count = 0;
    int             quiet_cycles = 0;
    int             settle_left = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;

    // Local copy of the alarm state and thresholds.
    logic [IDENT_W-1:0] model_ids   [SENSOR_SLOTS];
    logic [IDENT_W-1:0] model_rooms [SENSOR_SLOTS];
    int                 model_win   [SENSOR_SLOTS][WINDOW_LEN];
    int                 model_count = 0;
    int                 hot_limit  = int'(MAX_TEMP_RESET);
    int                 cold_limit = int'(MIN_TEMP_RESET);

    // Plan-time tracking of registrations, so random samples can hit known ids.
    logic [IDENT_W-1:0] plan_ids [SENSOR_SLOTS];
    int                 plan_count = 0;
    int                 plan_hot  = int'(MAX_TEMP_RESET);
    int                 plan_cold = int'(MIN_TEMP_RESET);

    per_sensor_moving_average_alarm dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .sensor_ident    (sensor_ident),
        .room_ident      (room_ident),
        .sample_value    (sample_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot_index      (slot_index),
        .room_out        (room_out),
        .running_average (running_average),
        .too_hot         (too_hot),
        .too_cold        (too_cold)
    );

    // Free-running clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Applies one transaction to the local alarm state and returns its result.
    function automatic psma_result_t compute_alarm(input logic op, input logic [IDENT_W-1:0] ident,
                                                   input logic [IDENT_W-1:0] room,
                                                   input logic [TEMP_W-1:0] temp);
        psma_result_t r;
        int           slot;
        int           total;
        int           divisor;
        int           avg;
        r = '0;
        if (op == FUNC_REGISTER)
        begin
            if (model_count >= SENSOR_SLOTS)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                slot = model_count;
                model_ids[slot]   = ident;
                model_rooms[slot] = room;
                for (int i = 0; i < WINDOW_LEN; i++)
                    model_win[slot][i] = 0;
                model_count = slot + 1;
                r.status = ST_REGISTERED;
                r.slot   = slot[SLOT_W-1:0];
                r.room   = room;
            end
            return r;
        end
        // Lowest matching slot wins when ids repeat.
        slot = -1;
        for (int i = 0; i < model_count; i++)
        begin
            if (slot < 0 && model_ids[i] == ident)
                slot = i;
        end
        if (slot < 0)
        begin
            r.status = ST_UNKNOWN;
            return r;
        end
        // Shift the window; zero-valued older samples drop out of the divisor.
        total   = 0;
        divisor = WINDOW_LEN;
        for (int i = 1; i < WINDOW_LEN; i++)
        begin
            model_win[slot][i-1] = model_win[slot][i];
            total += model_win[slot][i-1];
            if (model_win[slot][i-1] == 0)
                divisor--;
        end
        model_win[slot][WINDOW_LEN-1] = int'($signed(temp));
        total += int'($signed(temp));
        if (divisor < 1)
            divisor = 1;
        avg = total / divisor;
        if (avg > 32767)
            avg = 32767;
        if (avg < -32768)
            avg = -32768;
        r.status   = ST_AVERAGED;
        r.slot     = slot[SLOT_W-1:0];
        r.room     = model_rooms[slot];
        r.average  = avg[TEMP_W-1:0];
        r.too_hot  = (avg > hot_limit);
        r.too_cold = (avg < cold_limit);
        return r;
    endfunction

    // Appends an input transaction to the plan and tracks registrations.
    task automatic plan_item(input logic op, input logic [IDENT_W-1:0] ident,
                             input logic [IDENT_W-1:0] room, input logic [TEMP_W-1:0] temp);
        plan_entry_t e;
        e = '0;
        e.kind  = ENT_ITEM;
        e.op    = op;
        e.ident = ident;
        e.room  = room;
        e.temp  = temp;
        item_plan.push_back(e);
        total_items++;
        if (op == FUNC_REGISTER && plan_count < SENSOR_SLOTS)
        begin
            plan_ids[plan_count] = ident;
            plan_count++;
        end
    endtask

    // Appends one register write to the plan.
    task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data);
        plan_entry_t e;
        e = '0;
        e.kind      = ENT_CFG;
        e.reg_index = idx;
        e.reg_data  = data;
        item_plan.push_back(e);
        if (idx == CFG_MAX_TEMP)
            plan_hot = int'($signed(data));
        else if (idx == CFG_MIN_TEMP)
            plan_cold = int'($signed(data));
    endtask

    // Drains the block, then sets both thresholds.
    task automatic plan_thresholds(input logic [TEMP_W-1:0] hot, input logic [TEMP_W-1:0] cold);
        plan_entry_t e;
        e = '0;
        e.kind = ENT_SETTLE;
        item_plan.push_back(e);
        plan_write(CFG_MAX_TEMP, hot);
        plan_write(CFG_MIN_TEMP, cold);
    endtask

    // Sender idle percentage for the current phase of the run.
    function automatic int send_idle_pct();
        if (items_sent < total_items / 3)
            return 32;
        else if (items_sent < (2 * total_items) / 3)
            return 60;
        return 0;
    endfunction

    // Driver: offers plan entries, predicts results on acceptance.
    always @(posedge clk)
    begin : driver
        plan_entry_t e;
        bit          in_hold;
        bit          cfg_hold;
        bit          in_next;
        bit          cfg_next;
        if (rst_n)
        begin
            in_hold  = in_valid && !in_ready;
            cfg_hold = cfg_valid && !cfg_ready;
            if (in_valid && in_ready)
            begin
                pending_results.push_back(compute_alarm(func, sensor_ident, room_ident,
                                                        sample_value));
                items_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MAX_TEMP)
                    hot_limit = int'($signed(cfg_data));
                else if (cfg_index == CFG_MIN_TEMP)
                    cold_limit = int'($signed(cfg_data));
            end
            if (!in_hold && !cfg_hold)
            begin
                in_next  = 1'b0;
                cfg_next = 1'b0;
                if (settle_left > 0)
                begin
                    settle_left--;
                end
                else if (item_plan.size() > 0)
                begin
                    e = item_plan[0];
                    case (e.kind)
                        ENT_ITEM:
                        begin
                            if ($urandom_range(99) >= send_idle_pct())
                            begin
                                func         <= e.op;
                                sensor_ident <= e.ident;
                                room_ident   <= e.room;
                                sample_value <= e.temp;
                                in_next = 1'b1;
                                void'(item_plan.pop_front());
                            end
                        end
                        ENT_CFG:
                        begin
                            cfg_index <= e.reg_index;
                            cfg_data  <= e.reg_data;
                            cfg_next = 1'b1;
                            void'(item_plan.pop_front());
                        end
                        default:
                        begin
                            // Pause until every outstanding result is back.
                            if (pending_results.size() == 0)
                            begin
                                settle_left = SETTLE_CYCLES;
                                void'(item_plan.pop_front());
                            end
                        end
                    endcase
                end
                in_valid  <= in_next;
                cfg_valid <= cfg_next;
            end
        end
    end

    // Monitor: checks each result transaction and paces out_ready.
    always @(posedge clk)
    begin : monitor
        psma_result_t got;
        psma_result_t want;
        int           idle_pct;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.status   = status;
                got.slot     = slot_index;
                got.room     = room_out;
                got.average  = running_average;
                got.too_hot  = too_hot;
                got.too_cold = too_cold;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Unexpected result: status %0d slot %0d room %h",
                                 got.status, got.slot, got.room,
                                 " avg %0d hot %b cold %b",
                                 got.average, got.too_hot, got.too_cold);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("Mismatch on result %0d:", results_seen);
                            $display("  expected status %0d slot %0d room %h avg %0d hot %b cold %b",
                                     want.status, want.slot, want.room, want.average,
                                     want.too_hot, want.too_cold);
                            $display("  actual   status %0d slot %0d room %h avg %0d hot %b cold %b",
                                     got.status, got.slot, got.room, got.average,
                                     got.too_hot, got.too_cold);
                        end
                    end
                end
            end
            // Receiver idle rate mirrors the sender's phases.
            if (items_sent < total_items / 3)
                idle_pct = 60;
            else if (items_sent < (2 * total_items) / 3)
                idle_pct = 32;
            else
                idle_pct = 0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                // One long back-pressure stretch so the input side stalls.
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Counts cycles in which no transaction completes on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (cfg_valid && cfg_ready)
            || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Builds the plan, releases reset and decides the outcome.
    initial
    begin
        logic [IDENT_W-1:0] id;
        logic [TEMP_W-1:0]  temp;
        int                 pick;
        bit                 timed_out;

        // Directed part, run under the reset thresholds.
        total_items = 0;
        plan_item(FUNC_SAMPLE,   16'h1234, 16'h0000, 16'd100);
        plan_item(FUNC_REGISTER, 16'h0000, 16'hFFFF, 16'h0000);
        plan_item(FUNC_REGISTER, 16'hFFFF, 16'h0000, 16'hFFFF);
        plan_item(FUNC_REGISTER, 16'hFFFF, 16'h5A5A, 16'h0000);
        // Largest and smallest samples each fill a window; the duplicate id resolves to the lower slot.
        repeat (5) plan_item(FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        repeat (5) plan_item(FUNC_SAMPLE, 16'h0000, 16'h0000, 16'h8000);
        plan_item(FUNC_SAMPLE,   16'h0000, 16'hFFFF, 16'h0000);
        plan_item(FUNC_SAMPLE,   16'hABCD, 16'h0000, 16'h0001);
        // Threshold boundaries: equal is not flagged, a value just past is.
        plan_item(FUNC_REGISTER, 16'h0101, 16'h1234, 16'h0000);
        plan_item(FUNC_SAMPLE,   16'h0101, 16'h0000, 16'd6400);
        plan_item(FUNC_SAMPLE,   16'h0101, 16'h0000, 16'd6402);
        plan_item(FUNC_REGISTER, 16'h8000, 16'h8001, 16'h0000);
        plan_item(FUNC_SAMPLE,   16'h8000, 16'h0000, 16'd2560);
        plan_item(FUNC_SAMPLE,   16'h8000, 16'h0000, 16'd2557);
        // Negative sums truncate toward zero.
        plan_item(FUNC_REGISTER, 16'h7FFF, 16'h7FFF, 16'h0000);
        plan_item(FUNC_SAMPLE,   16'h7FFF, 16'h0000, -16'sd3);
        plan_item(FUNC_SAMPLE,   16'h7FFF, 16'h0000, -16'sd4);

        // Random part in segments, each under its own thresholds.
        for (int seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            case (seg)
                0: plan_thresholds(16'h7FFF, 16'h8000);
                1: plan_thresholds(16'h8000, 16'h7FFF);
                2: plan_thresholds(16'h0000, 16'h0000);
                3:
                begin
                    plan_thresholds(TEMP_W'($urandom_range(12800)),
                                    TEMP_W'($urandom_range(6400)));
                    // Indexes past the two registers must be ignored.
                    plan_write(2'd2, TEMP_W'($urandom_range(65535)));
                    plan_write(2'd3, TEMP_W'($urandom_range(65535)));
                end
                4: plan_thresholds(TEMP_W'($urandom_range(65535)),
                                   TEMP_W'($urandom_range(65535)));
                default: plan_thresholds(MAX_TEMP_RESET, MIN_TEMP_RESET);
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                case ($urandom_range(99) / 10)
                    0: temp = '0;
                    1: temp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                    2, 3: temp = TEMP_W'(($urandom_range(1) ? plan_hot : plan_cold)
                                         + $urandom_range(16) - 8);
                    4, 5: temp = TEMP_W'($urandom_range(12800) - 1280);
                    default: temp = TEMP_W'($urandom_range(65535));
                endcase
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    // Registration, sometimes reusing an existing id.
                    if (plan_count > 0 && $urandom_range(3) == 0)
                        id = plan_ids[$urandom_range(plan_count - 1)];
                    else
                        id = IDENT_W'($urandom_range(65535));
                    plan_item(FUNC_REGISTER, id, IDENT_W'($urandom_range(65535)), temp);
                end
                else if (pick < 15 || plan_count == 0)
                begin
                    plan_item(FUNC_SAMPLE, IDENT_W'($urandom_range(65535)),
                              IDENT_W'($urandom_range(65535)), temp);
                end
                else
                begin
                    id = plan_ids[$urandom_range(plan_count - 1)];
                    plan_item(FUNC_SAMPLE, id, IDENT_W'($urandom_range(65535)), temp);
                end
            end
        end

        // Reset held from time zero, released at a rising edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (!(item_plan.size() == 0 && !in_valid && !cfg_valid
                 && pending_results.size() == 0) && quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        timed_out = (quiet_cycles >= QUIET_LIMIT);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge clk);
        if (!timed_out && fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
